>>> sv/sha384_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-384 package
// Shared types, constants and round functions of the SHA-384 hash engine.
// ----------------------------------------------------------------------------
package sha384_pkg;

    typedef logic [63:0] t_word;

    localparam int unsigned NUM_ROUNDS   = 80;
    localparam int unsigned WINDOW_DEPTH = 16;
    localparam int unsigned DIGEST_WORDS = 6;

    localparam logic [6:0] LAST_ROUND   = 7'(NUM_ROUNDS - 1);
    localparam logic [6:0] FOLD_ROUND   = 7'(NUM_ROUNDS);
    localparam logic [3:0] LAST_SLOT    = 4'(WINDOW_DEPTH - 1);
    localparam logic [3:0] LEN_HI_SLOT  = 4'(WINDOW_DEPTH - 2);
    localparam logic [2:0] LAST_DIGEST  = 3'(DIGEST_WORDS - 1);
    localparam logic [7:0] PAD_BYTE     = 8'h80;

    localparam t_word INIT_HASH [8] = '{
        64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507,
        64'h9159015a3070dd17, 64'h152fecd8f70e5939,
        64'h67332667ffc00b31, 64'h8eb44a8768581511,
        64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_FIRST,
        ST_PAD_FILL,
        ST_DRAIN,
        ST_OUT
    } t_state;

    // Requests from the sequencer to the compression unit.
    typedef struct packed {
        logic       shift;
        logic       start;
        logic       init;
        logic [2:0] rd_idx;
    } t_cmp_req;

    function automatic t_word rotr(input t_word x, input logic [5:0] n);
        rotr = (x >> n) | (x << (7'd64 - {1'b0, n}));
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        big_sigma0 = rotr(x, 6'd28) ^ rotr(x, 6'd34) ^ rotr(x, 6'd39);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        big_sigma1 = rotr(x, 6'd14) ^ rotr(x, 6'd18) ^ rotr(x, 6'd41);
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        small_sigma0 = rotr(x, 6'd1) ^ rotr(x, 6'd8) ^ (x >> 7);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        small_sigma1 = rotr(x, 6'd19) ^ rotr(x, 6'd61) ^ (x >> 6);
    endfunction

    function automatic t_word round_k(input logic [6:0] t);
        unique case (t)
            7'd0:  round_k = 64'h428a2f98d728ae22;
            7'd1:  round_k = 64'h7137449123ef65cd;
            7'd2:  round_k = 64'hb5c0fbcfec4d3b2f;
            7'd3:  round_k = 64'he9b5dba58189dbbc;
            7'd4:  round_k = 64'h3956c25bf348b538;
            7'd5:  round_k = 64'h59f111f1b605d019;
            7'd6:  round_k = 64'h923f82a4af194f9b;
            7'd7:  round_k = 64'hab1c5ed5da6d8118;
            7'd8:  round_k = 64'hd807aa98a3030242;
            7'd9:  round_k = 64'h12835b0145706fbe;
            7'd10: round_k = 64'h243185be4ee4b28c;
            7'd11: round_k = 64'h550c7dc3d5ffb4e2;
            7'd12: round_k = 64'h72be5d74f27b896f;
            7'd13: round_k = 64'h80deb1fe3b1696b1;
            7'd14: round_k = 64'h9bdc06a725c71235;
            7'd15: round_k = 64'hc19bf174cf692694;
            7'd16: round_k = 64'he49b69c19ef14ad2;
            7'd17: round_k = 64'hefbe4786384f25e3;
            7'd18: round_k = 64'h0fc19dc68b8cd5b5;
            7'd19: round_k = 64'h240ca1cc77ac9c65;
            7'd20: round_k = 64'h2de92c6f592b0275;
            7'd21: round_k = 64'h4a7484aa6ea6e483;
            7'd22: round_k = 64'h5cb0a9dcbd41fbd4;
            7'd23: round_k = 64'h76f988da831153b5;
            7'd24: round_k = 64'h983e5152ee66dfab;
            7'd25: round_k = 64'ha831c66d2db43210;
            7'd26: round_k = 64'hb00327c898fb213f;
            7'd27: round_k = 64'hbf597fc7beef0ee4;
            7'd28: round_k = 64'hc6e00bf33da88fc2;
            7'd29: round_k = 64'hd5a79147930aa725;
            7'd30: round_k = 64'h06ca6351e003826f;
            7'd31: round_k = 64'h142929670a0e6e70;
            7'd32: round_k = 64'h27b70a8546d22ffc;
            7'd33: round_k = 64'h2e1b21385c26c926;
            7'd34: round_k = 64'h4d2c6dfc5ac42aed;
            7'd35: round_k = 64'h53380d139d95b3df;
            7'd36: round_k = 64'h650a73548baf63de;
            7'd37: round_k = 64'h766a0abb3c77b2a8;
            7'd38: round_k = 64'h81c2c92e47edaee6;
            7'd39: round_k = 64'h92722c851482353b;
            7'd40: round_k = 64'ha2bfe8a14cf10364;
            7'd41: round_k = 64'ha81a664bbc423001;
            7'd42: round_k = 64'hc24b8b70d0f89791;
            7'd43: round_k = 64'hc76c51a30654be30;
            7'd44: round_k = 64'hd192e819d6ef5218;
            7'd45: round_k = 64'hd69906245565a910;
            7'd46: round_k = 64'hf40e35855771202a;
            7'd47: round_k = 64'h106aa07032bbd1b8;
            7'd48: round_k = 64'h19a4c116b8d2d0c8;
            7'd49: round_k = 64'h1e376c085141ab53;
            7'd50: round_k = 64'h2748774cdf8eeb99;
            7'd51: round_k = 64'h34b0bcb5e19b48a8;
            7'd52: round_k = 64'h391c0cb3c5c95a63;
            7'd53: round_k = 64'h4ed8aa4ae3418acb;
            7'd54: round_k = 64'h5b9cca4f7763e373;
            7'd55: round_k = 64'h682e6ff3d6b2b8a3;
            7'd56: round_k = 64'h748f82ee5defb2fc;
            7'd57: round_k = 64'h78a5636f43172f60;
            7'd58: round_k = 64'h84c87814a1f0ab72;
            7'd59: round_k = 64'h8cc702081a6439ec;
            7'd60: round_k = 64'h90befffa23631e28;
            7'd61: round_k = 64'ha4506cebde82bde9;
            7'd62: round_k = 64'hbef9a3f7b2c67915;
            7'd63: round_k = 64'hc67178f2e372532b;
            7'd64: round_k = 64'hca273eceea26619c;
            7'd65: round_k = 64'hd186b8c721c0c207;
            7'd66: round_k = 64'heada7dd6cde0eb1e;
            7'd67: round_k = 64'hf57d4f7fee6ed178;
            7'd68: round_k = 64'h06f067aa72176fba;
            7'd69: round_k = 64'h0a637dc5a2c898a6;
            7'd70: round_k = 64'h113f9804bef90dae;
            7'd71: round_k = 64'h1b710b35131c471b;
            7'd72: round_k = 64'h28db77f523047da8;
            7'd73: round_k = 64'h32caab7b40c72493;
            7'd74: round_k = 64'h3c9ebe0a15c9bebc;
            7'd75: round_k = 64'h431d67c49c100d4c;
            7'd76: round_k = 64'h4cc5d4becb3e42b6;
            7'd77: round_k = 64'h597f299cfc657e2a;
            7'd78: round_k = 64'h5fcb6fab3ad6faec;
            7'd79: round_k = 64'h6c44198c4a475817;
            default: round_k = '0;
        endcase
    endfunction

endpackage

>>> sv/sha384_compress.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-384 compression unit
// Holds the chaining value, the working variables and the 16-word message
// schedule as a shift line; runs one SHA-512 round per cycle.
// ----------------------------------------------------------------------------
module sha384_compress (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha384_pkg::t_cmp_req i_req,
    input  sha384_pkg::t_word    i_wr_data,
    output logic                 o_busy,
    output sha384_pkg::t_word    o_rd_word
);

    logic              r_busy;
    logic [6:0]        r_round;
    sha384_pkg::t_word r_win   [16];
    sha384_pkg::t_word r_wv    [8];
    sha384_pkg::t_word r_chain [8];

    sha384_pkg::t_word w_t1;
    sha384_pkg::t_word w_t2;
    sha384_pkg::t_word w_sched;

    // The oldest window entry is the word of the current round; the new
    // schedule word is shifted in behind it.
    always_comb begin
        w_t1 = r_wv[7] + sha384_pkg::big_sigma1(r_wv[4])
             + ((r_wv[4] & r_wv[5]) ^ (~r_wv[4] & r_wv[6]))
             + sha384_pkg::round_k(r_round) + r_win[0];
        w_t2 = sha384_pkg::big_sigma0(r_wv[0])
             + ((r_wv[0] & r_wv[1]) ^ (r_wv[0] & r_wv[2]) ^ (r_wv[1] & r_wv[2]));
        w_sched = sha384_pkg::small_sigma1(r_win[14]) + r_win[9]
                + sha384_pkg::small_sigma0(r_win[1]) + r_win[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= '0;
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= sha384_pkg::INIT_HASH[i];
            end
        end else if (r_busy) begin
            if (r_round == sha384_pkg::FOLD_ROUND) begin
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= r_chain[i] + r_wv[i];
                end
                r_busy  <= 1'b0;
                r_round <= '0;
            end else begin
                r_round <= r_round + 7'd1;
            end
        end else begin
            if (i_req.init) begin
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= sha384_pkg::INIT_HASH[i];
                end
            end
            if (i_req.start) begin
                r_busy <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && r_round != sha384_pkg::FOLD_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[15] <= w_sched;
            r_wv[7] <= r_wv[6];
            r_wv[6] <= r_wv[5];
            r_wv[5] <= r_wv[4];
            r_wv[4] <= r_wv[3] + w_t1;
            r_wv[3] <= r_wv[2];
            r_wv[2] <= r_wv[1];
            r_wv[1] <= r_wv[0];
            r_wv[0] <= w_t1 + w_t2;
        end else if (!r_busy) begin
            if (i_req.shift) begin
                for (int i = 0; i < 15; i++) begin
                    r_win[i] <= r_win[i + 1];
                end
                r_win[15] <= i_wr_data;
            end
            if (i_req.start) begin
                for (int i = 0; i < 8; i++) begin
                    r_wv[i] <= r_chain[i];
                end
            end
        end
    end

    assign o_busy    = r_busy;
    assign o_rd_word = r_chain[i_req.rd_idx];

`ifndef SYNTHESIS
    a_no_shift_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.shift |-> !r_busy)
        else $error("schedule shifted while rounds run");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("compression started while busy");
    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_round <= sha384_pkg::FOLD_ROUND)
        else $error("round counter out of range");
    a_full_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) && $past(i_rst_n) |-> $past(r_round) == sha384_pkg::FOLD_ROUND)
        else $error("compression ended before all rounds");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start && !r_busy |=> r_busy && r_round == '0)
        else $error("start did not launch the rounds");
`endif

endmodule

>>> sv/sha384_hash_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-384 hash engine
// Absorbs a message as 64-bit big-endian words, pads it and emits the digest.
// ----------------------------------------------------------------------------
// Usage: message words arrive on the s_axis channel, tdata holding the bytes
// (first byte in bits 63..56), tuser the count of valid bytes and tlast the
// final word of the message. Only the final word may be partial or empty.
// A word is taken while the engine awaits words and the compression unit is
// idle. Every sixteenth word starts a compression (80 rounds, one per cycle,
// then the fold into the chaining value), during which tready is low. After
// the final word the engine writes the padding byte, zero words and the bit
// length one per cycle while the compression unit is idle, and runs one or
// two more compressions, two when the length needs an extra block; the first
// digest word is offered once the last compression is done. The six words go
// out on m_axis most significant first, tuser giving the word index and tlast
// marking the sixth. A stalled receiver holds the current word; no new
// message is taken until all six are delivered, after which the hash state
// starts over. A synchronous reset (i_rst_n low) aborts any message; the
// engine is ready right after it.
// ----------------------------------------------------------------------------
module sha384_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // data_word[63:0]
    input  logic [3:0]  s_axis_tuser,   // byte_count[3:0]
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // digest_word[63:0]
    output logic [2:0]  m_axis_tuser,   // word_index[2:0]
    output logic        m_axis_tlast    // last
);

    sha384_pkg::t_state   r_state, n_state;
    logic [3:0]           r_pos, n_pos;
    logic [63:0]          r_bitlen, n_bitlen;
    sha384_pkg::t_word    r_pad_word, n_pad_word;
    logic                 r_len_ok, n_len_ok;
    logic [2:0]           r_idx, n_idx;

    sha384_pkg::t_cmp_req w_req;
    sha384_pkg::t_word    w_wr_data;
    sha384_pkg::t_word    w_rd_word;
    sha384_pkg::t_word    w_tail_word;
    logic                 w_busy;
    logic                 w_accept;

    sha384_compress u_compress (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .i_wr_data (w_wr_data),
        .o_busy    (w_busy),
        .o_rd_word (w_rd_word)
    );

    // Final partial word: valid bytes kept, the padding byte right after
    // them, and zeros below.
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            if (3'(i) < s_axis_tuser[2:0]) begin
                w_tail_word[63 - 8*i -: 8] = s_axis_tdata[63 - 8*i -: 8];
            end else if (3'(i) == s_axis_tuser[2:0]) begin
                w_tail_word[63 - 8*i -: 8] = sha384_pkg::PAD_BYTE;
            end else begin
                w_tail_word[63 - 8*i -: 8] = 8'h00;
            end
        end
    end

    assign w_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sha384_pkg::ST_IDLE;
            r_pos    <= '0;
            r_bitlen <= '0;
            r_len_ok <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_bitlen <= n_bitlen;
            r_len_ok <= n_len_ok;
            r_idx    <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pad_word <= n_pad_word;
    end

    always_comb begin
        n_state       = r_state;
        n_pos         = r_pos;
        n_bitlen      = r_bitlen;
        n_pad_word    = r_pad_word;
        n_len_ok      = r_len_ok;
        n_idx         = r_idx;
        w_req         = '0;
        w_req.rd_idx  = r_idx;
        w_wr_data     = '0;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;

        unique case (r_state)
            sha384_pkg::ST_IDLE: begin
                s_axis_tready = !w_busy;
                if (w_accept) begin
                    if (!s_axis_tlast || s_axis_tuser[3]) begin
                        w_req.shift = 1'b1;
                        w_req.start = (r_pos == sha384_pkg::LAST_SLOT);
                        w_wr_data   = s_axis_tdata;
                        n_pos       = r_pos + 4'd1;
                        n_bitlen    = r_bitlen + 64'd64;
                    end else begin
                        n_bitlen = r_bitlen + {58'd0, s_axis_tuser[2:0], 3'd0};
                    end
                    if (s_axis_tlast) begin
                        n_pad_word = s_axis_tuser[3]
                                   ? {sha384_pkg::PAD_BYTE, 56'd0} : w_tail_word;
                        n_state    = sha384_pkg::ST_PAD_FIRST;
                    end
                end
            end
            sha384_pkg::ST_PAD_FIRST: begin
                if (!w_busy) begin
                    w_req.shift = 1'b1;
                    w_req.start = (r_pos == sha384_pkg::LAST_SLOT);
                    w_wr_data   = r_pad_word;
                    // Padding in the slot of the length's upper half leaves no room,
                    // so the length moves to an extra block.
                    n_len_ok    = (r_pos != sha384_pkg::LEN_HI_SLOT);
                    n_pos       = r_pos + 4'd1;
                    n_state     = sha384_pkg::ST_PAD_FILL;
                end
            end
            sha384_pkg::ST_PAD_FILL: begin
                if (!w_busy) begin
                    w_req.shift = 1'b1;
                    n_pos       = r_pos + 4'd1;
                    if (r_pos == sha384_pkg::LAST_SLOT) begin
                        w_req.start = 1'b1;
                        if (r_len_ok) begin
                            w_wr_data = r_bitlen;
                            n_state   = sha384_pkg::ST_DRAIN;
                        end else begin
                            n_len_ok = 1'b1;
                        end
                    end
                end
            end
            sha384_pkg::ST_DRAIN: begin
                if (!w_busy) begin
                    n_idx   = '0;
                    n_state = sha384_pkg::ST_OUT;
                end
            end
            sha384_pkg::ST_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    if (r_idx == sha384_pkg::LAST_DIGEST) begin
                        w_req.init = 1'b1;
                        n_bitlen   = '0;
                        n_pos      = '0;
                        n_idx      = '0;
                        n_state    = sha384_pkg::ST_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = sha384_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tdata = w_rd_word;
    assign m_axis_tuser = r_idx;
    assign m_axis_tlast = (r_idx == sha384_pkg::LAST_DIGEST);

endmodule
